[src/skit_pkg.sv]
// ----------------------------------------------------------------------------
// skit_pkg
// Shared widths, codes and controller/datapath interface types for the
// sorted key index table.
// ----------------------------------------------------------------------------
package skit_pkg;

  // Default sizes handed to the top level
  localparam int DEF_TABLE_ENTRIES = 1024;
  localparam int DEF_KEY_BITS      = 20;

  // Fixed field widths
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 20;
  localparam int BLK_W  = 16;
  localparam int SLOT_W = 8;
  localparam int POS_W  = 11;
  localparam int STAT_W = 2;

  localparam int IN_DATA_W  = 48;  // 46 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 56;  // 49 bits of fields, padded to bytes

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch the item, open the search window
    logic srch_rd;   // read probe entry (mid, or lo when window closed)
    logic srch_upd;  // narrow the search window
    logic hit_chk;   // settle hit, status and shift index
    logic shu_rd;    // read entry idx-1
    logic shu_wr;    // write it to idx, step idx down
    logic shd_rd;    // read entry idx+1
    logic shd_wr;    // write it to idx, step idx up
    logic ins_wr;    // write the new entry at its position
    logic load_out;  // load result register, update entry count
  } skit_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic srch_go;    // window not empty
    logic hit;        // probed entry matches the key
    logic is_ins;
    logic is_rem;
    logic full;
    logic ins_shift;  // entries above the insert point must move
    logic rem_shift;  // entries above the removed one must move
    logic shu_more;
    logic shd_more;
  } skit_sts_t;

endpackage

[src/skit_ctrl.sv]
// ----------------------------------------------------------------------------
// skit_ctrl
// Sequencer for search, shift and insert steps, plus result handshake.
// ----------------------------------------------------------------------------
module skit_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  skit_pkg::skit_sts_t sts,
  output skit_pkg::skit_cmd_t cmd
);
  import skit_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SADDR  = 4'd1;
  localparam logic [3:0] S_SCMP   = 4'd2;
  localparam logic [3:0] S_HCHK   = 4'd3;
  localparam logic [3:0] S_SHU_RD = 4'd4;
  localparam logic [3:0] S_SHU_WR = 4'd5;
  localparam logic [3:0] S_SHD_RD = 4'd6;
  localparam logic [3:0] S_SHD_WR = 4'd7;
  localparam logic [3:0] S_INS    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_SADDR;
        end
      end
      S_SADDR: begin
        cmd.srch_rd = 1'b1;
        state_nxt   = sts.srch_go ? S_SCMP : S_HCHK;
      end
      S_SCMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SADDR;
      end
      S_HCHK: begin
        cmd.hit_chk = 1'b1;
        if (sts.is_ins && !sts.hit && !sts.full) begin
          state_nxt = sts.ins_shift ? S_SHU_RD : S_INS;
        end else if (sts.is_rem && sts.hit) begin
          state_nxt = sts.rem_shift ? S_SHD_RD : S_FIN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SHU_RD: begin
        cmd.shu_rd = 1'b1;
        state_nxt  = S_SHU_WR;
      end
      S_SHU_WR: begin
        cmd.shu_wr = 1'b1;
        state_nxt  = sts.shu_more ? S_SHU_RD : S_INS;
      end
      S_SHD_RD: begin
        cmd.shd_rd = 1'b1;
        state_nxt  = S_SHD_WR;
      end
      S_SHD_WR: begin
        cmd.shd_wr = 1'b1;
        state_nxt  = sts.shd_more ? S_SHD_RD : S_FIN;
      end
      S_INS: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A finished item leaves as soon as the result register is free
  a_fin_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (state_r == S_IDLE && out_valid_r))
    else $error("finished item not handed to result register");

  // Only one table write kind per cycle
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.shu_wr, cmd.shd_wr, cmd.ins_wr}))
    else $error("conflicting table writes");

endmodule

[src/skit_dp.sv]
// ----------------------------------------------------------------------------
// skit_dp
// Table memory, search window, shift index, entry count and result register.
// ----------------------------------------------------------------------------
module skit_dp #(
  parameter int TABLE_ENTRIES = skit_pkg::DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = skit_pkg::DEF_KEY_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  skit_pkg::skit_cmd_t                 cmd,
  output skit_pkg::skit_sts_t                 sts,
  input  logic [skit_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic [skit_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import skit_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = KEY_BITS + BLK_W + SLOT_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(TABLE_ENTRIES);

  logic [EW-1:0] mem [TABLE_ENTRIES];

  logic [CMD_W-1:0]    op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [BLK_W-1:0]    blk_r, fblk_r;
  logic [SLOT_W-1:0]   slot_r, fslt_r;
  logic [CW-1:0]       lo_r, hi_r, idx_r, cnt_r;
  logic [EW-1:0]       rd_r;
  logic                hit_r, inc_r, dec_r;
  logic [STAT_W-1:0]   stat_r;
  logic [OUT_DATA_W-1:0] out_r;

  logic [CW-1:0]       mid, cnt_new;
  logic [KEY_BITS-1:0] rd_key;
  logic                hit_now, full, is_ins, is_rem;
  logic [CW:0]         lo_p1, idx_p2;
  logic [CW-1:0]       raddr_w, waddr_w;
  logic [EW-1:0]       wdata;
  logic                re, we;
  logic [STAT_W-1:0]   stat_new;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_key  = rd_r[EW-1:BLK_W+SLOT_W];
  assign hit_now = (lo_r < cnt_r) && (rd_key == key_r);
  assign full    = (cnt_r == CNT_MAX);
  assign is_ins  = (op_r == CMD_INSERT);
  assign is_rem  = (op_r == CMD_REMOVE);
  assign lo_p1   = {1'b0, lo_r} + 1'b1;
  assign idx_p2  = {1'b0, idx_r} + 2'd2;

  // Status to controller
  assign sts.srch_go   = lo_r < hi_r;
  assign sts.hit       = hit_now;
  assign sts.is_ins    = is_ins;
  assign sts.is_rem    = is_rem;
  assign sts.full      = full;
  assign sts.ins_shift = cnt_r > lo_r;
  assign sts.rem_shift = lo_p1 < {1'b0, cnt_r};
  assign sts.shu_more  = {1'b0, idx_r} > lo_p1;
  assign sts.shd_more  = idx_p2 < {1'b0, cnt_r};

  // Memory address and data selection
  always_comb begin
    re      = cmd.srch_rd || cmd.shu_rd || cmd.shd_rd;
    we      = cmd.shu_wr || cmd.shd_wr || cmd.ins_wr;
    raddr_w = lo_r;
    if (cmd.srch_rd) begin
      raddr_w = (lo_r < hi_r) ? mid : lo_r;
    end else if (cmd.shu_rd) begin
      raddr_w = idx_r - 1'b1;
    end else if (cmd.shd_rd) begin
      raddr_w = idx_r + 1'b1;
    end
    waddr_w = cmd.ins_wr ? lo_r : idx_r;
    wdata   = cmd.ins_wr ? {key_r, blk_r, slot_r} : rd_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr_w[AW-1:0]] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr_w[AW-1:0]];
    end
  end

  // Outcome of the command once the probe is settled
  always_comb begin
    if (is_ins) begin
      stat_new = hit_now ? STAT_DUP : (full ? STAT_FULL : STAT_OK);
    end else begin
      stat_new = hit_now ? STAT_OK : STAT_MISS;
    end
  end

  assign cnt_new = cnt_r + CW'(inc_r) - CW'(dec_r);

  // Item, search window and shift index
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= in_tdata[1:0];
      key_r  <= KEY_BITS'(in_tdata[21:2]);
      blk_r  <= in_tdata[37:22];
      slot_r <= in_tdata[45:38];
      lo_r   <= '0;
      hi_r   <= cnt_r;
    end
    if (cmd.srch_upd) begin
      if (rd_key < key_r) begin
        lo_r <= mid + 1'b1;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.hit_chk) begin
      hit_r  <= hit_now;
      fblk_r <= hit_now ? rd_r[BLK_W+SLOT_W-1:SLOT_W] : '0;
      fslt_r <= hit_now ? rd_r[SLOT_W-1:0] : '0;
      stat_r <= stat_new;
      inc_r  <= is_ins && !hit_now && !full;
      dec_r  <= is_rem && hit_now;
      idx_r  <= is_ins ? cnt_r : lo_r;
    end
    if (cmd.shu_wr) begin
      idx_r <= idx_r - 1'b1;
    end
    if (cmd.shd_wr) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_r <= {7'd0, stat_r, POS_W'(cnt_new), fslt_r, fblk_r, POS_W'(lo_r), hit_r};
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load_out) begin
      cnt_r <= cnt_new;
    end
  end

  assign out_tdata = out_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("entry count above table size");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> (cnt_r < CNT_MAX))
    else $error("insert into full table");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_upd |-> (lo_r < hi_r && hi_r <= cnt_r))
    else $error("search window out of order");

endmodule

[src/sorted_key_index_table_core.sv]
// ----------------------------------------------------------------------------
// sorted_key_index_table_core
// Sorted table of (key, block, slot) with lookup, insert and remove by key.
//
//   Channel  Direction  Ports                       Contents
//   in_      slave      in_tvalid/tready/tdata      command, key, block, slot
//   out_     master     out_tvalid/tready/tdata     one result per item
//
// An item runs the binary search and the result step, plus a read step and
// a write step per entry moved on insert or remove and one insert write;
// the table memory has a single read port.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
// One item is in work at a time; the next is taken once the last result is
// loaded into the output register, which holds while out_tready is low.
// ----------------------------------------------------------------------------
module sorted_key_index_table_core #(
  parameter int TABLE_ENTRIES = skit_pkg::DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = skit_pkg::DEF_KEY_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // command[1:0], key[21:2], block_number[37:22], slot[45:38]
  input  logic [skit_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // found[0], position[11:1], found_block[27:12], found_slot[35:28],
  // entry_total[46:36], status[48:47]
  output logic [skit_pkg::OUT_DATA_W-1:0] out_tdata
);
  import skit_pkg::*;

  skit_cmd_t cmd;
  skit_sts_t sts;

  skit_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  skit_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
